// ===== hw/rtl/etcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etcc_pkg: shared types and constants for the ellipsoid clearance check
// Word formats, table entry layout, microcode control word and datapath
// control/status bundles.
// ----------------------------------------------------------------------------
package etcc_pkg;

    localparam int MAX_THREATS_DEF = 32;

    localparam int COORD_W = 20;   // signed coordinate, 1/16 m
    localparam int AXIS_W  = 16;   // unsigned semi-axis, 1/16 m
    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 6;    // threat_count register
    localparam int HIT_W   = 5;
    localparam int DIFF_W  = 20;   // |p - c| always fits in 20 bits
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int OPND_W  = 32;
    localparam int PROD_W  = 2 * OPND_W;
    // lhs < 3 * 2^104, rhs < 2^96: signed difference fits in 108 bits
    localparam int ACC_W   = 108;
    localparam int PC_W    = 5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [AXIS_W-1:0]         semi_a;
        logic [AXIS_W-1:0]         semi_b;
        logic [AXIS_W-1:0]         semi_c;
    } in_word_t;

    typedef struct packed {
        logic             safe;
        logic [HIT_W-1:0] hit_index;
    } out_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [AXIS_W-1:0]         a;
        logic [AXIS_W-1:0]         b;
        logic [AXIS_W-1:0]         c;
    } threat_ent_t;

    // Sequencer operation of one microcode step
    typedef enum logic [2:0] {
        SEQ_WAIT,       // take input words, stay until a query arrives
        SEQ_NEXT,       // fall through
        SEQ_JUMP,       // go to target
        SEQ_TEST,       // all entries done: go to target, else fall through
        SEQ_CHECK,      // inside: fall through, else bump index, go to target
        SEQ_EMIT_HIT,   // post a hit result when the output is free
        SEQ_EMIT_SAFE   // post a safe result when the output is free
    } seq_op_t;

    // Multiplier operand sources, 32 bits each
    typedef enum logic [4:0] {
        OPD_ZERO,
        OPD_A, OPD_B, OPD_C,
        OPD_DX, OPD_DY, OPD_DZ,
        OPD_A2, OPD_B2, OPD_C2,
        OPD_AB_LO, OPD_AB_HI,
        OPD_AC_LO, OPD_AC_HI,
        OPD_BC_LO, OPD_BC_HI,
        OPD_DX2_LO, OPD_DX2_HI,
        OPD_DY2_LO, OPD_DY2_HI,
        OPD_DZ2_LO, OPD_DZ2_HI
    } opnd_t;

    // Destination of the previous step's product
    typedef enum logic [3:0] {
        DST_NONE,
        DST_A2, DST_B2, DST_C2,
        DST_AB, DST_AC, DST_BC,
        DST_DX2, DST_DY2, DST_DZ2
    } dst_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_32,
        SH_64
    } shift_t;

    typedef struct packed {
        seq_op_t         seq;
        logic [PC_W-1:0] target;
        logic            rd_en;
        logic            ld_diff;
        opnd_t           opa;
        opnd_t           opb;
        dst_t            dst;
        acc_op_t         acc;
        shift_t          shift;
    } ctrl_word_t;

    typedef struct packed {
        logic    mem_we;
        logic    pt_ld;
        logic    rd_en;
        logic    ld_diff;
        opnd_t   opa;
        opnd_t   opb;
        dst_t    dst;
        acc_op_t acc;
        shift_t  shift;
    } dp_ctrl_t;

    typedef struct packed {
        logic acc_neg;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/etcc_ucode_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etcc_ucode_rom: microprogram of the clearance check
// One control word per step. The multiply fields act in the current step;
// the dst and acc fields consume the product of the previous step.
// ----------------------------------------------------------------------------
module etcc_ucode_rom (
    input  wire logic [etcc_pkg::PC_W-1:0] pc,
    output etcc_pkg::ctrl_word_t           uc
);

    localparam logic [etcc_pkg::PC_W-1:0] PC_WAIT = etcc_pkg::PC_W'(0);
    localparam logic [etcc_pkg::PC_W-1:0] PC_TEST = etcc_pkg::PC_W'(1);
    localparam logic [etcc_pkg::PC_W-1:0] PC_SAFE = etcc_pkg::PC_W'(28);

    function automatic etcc_pkg::ctrl_word_t uw(
        input etcc_pkg::seq_op_t          seq,
        input logic [etcc_pkg::PC_W-1:0]  target,
        input logic                       rd_en,
        input logic                       ld_diff,
        input etcc_pkg::opnd_t            opa,
        input etcc_pkg::opnd_t            opb,
        input etcc_pkg::dst_t             dst,
        input etcc_pkg::acc_op_t          acc,
        input etcc_pkg::shift_t           shift
    );
        etcc_pkg::ctrl_word_t w;
        w.seq     = seq;
        w.target  = target;
        w.rd_en   = rd_en;
        w.ld_diff = ld_diff;
        w.opa     = opa;
        w.opb     = opb;
        w.dst     = dst;
        w.acc     = acc;
        w.shift   = shift;
        return w;
    endfunction

    // Plain multiply step: product into the previous step's destination
    function automatic etcc_pkg::ctrl_word_t mul(
        input etcc_pkg::opnd_t   opa,
        input etcc_pkg::opnd_t   opb,
        input etcc_pkg::dst_t    dst,
        input etcc_pkg::acc_op_t acc,
        input etcc_pkg::shift_t  shift
    );
        return uw(etcc_pkg::SEQ_NEXT, PC_WAIT, 1'b0, 1'b0, opa, opb, dst, acc, shift);
    endfunction

    // Program: squares, pairwise products, then lhs - rhs in 32-bit limbs
    always_comb begin
        unique case (pc)
            5'd0:  uc = uw(etcc_pkg::SEQ_WAIT, PC_WAIT, 1'b0, 1'b0, etcc_pkg::OPD_ZERO,
                           etcc_pkg::OPD_ZERO, etcc_pkg::DST_NONE, etcc_pkg::ACC_HOLD,
                           etcc_pkg::SH_0);
            5'd1:  uc = uw(etcc_pkg::SEQ_TEST, PC_SAFE, 1'b1, 1'b0, etcc_pkg::OPD_ZERO,
                           etcc_pkg::OPD_ZERO, etcc_pkg::DST_NONE, etcc_pkg::ACC_HOLD,
                           etcc_pkg::SH_0);
            5'd2:  uc = uw(etcc_pkg::SEQ_NEXT, PC_WAIT, 1'b0, 1'b1, etcc_pkg::OPD_A,
                           etcc_pkg::OPD_A, etcc_pkg::DST_NONE, etcc_pkg::ACC_CLR,
                           etcc_pkg::SH_0);
            5'd3:  uc = mul(etcc_pkg::OPD_B, etcc_pkg::OPD_B, etcc_pkg::DST_A2,
                            etcc_pkg::ACC_HOLD, etcc_pkg::SH_0);
            5'd4:  uc = mul(etcc_pkg::OPD_C, etcc_pkg::OPD_C, etcc_pkg::DST_B2,
                            etcc_pkg::ACC_HOLD, etcc_pkg::SH_0);
            5'd5:  uc = mul(etcc_pkg::OPD_DX, etcc_pkg::OPD_DX, etcc_pkg::DST_C2,
                            etcc_pkg::ACC_HOLD, etcc_pkg::SH_0);
            5'd6:  uc = mul(etcc_pkg::OPD_DY, etcc_pkg::OPD_DY, etcc_pkg::DST_DX2,
                            etcc_pkg::ACC_HOLD, etcc_pkg::SH_0);
            5'd7:  uc = mul(etcc_pkg::OPD_DZ, etcc_pkg::OPD_DZ, etcc_pkg::DST_DY2,
                            etcc_pkg::ACC_HOLD, etcc_pkg::SH_0);
            5'd8:  uc = mul(etcc_pkg::OPD_A2, etcc_pkg::OPD_B2, etcc_pkg::DST_DZ2,
                            etcc_pkg::ACC_HOLD, etcc_pkg::SH_0);
            5'd9:  uc = mul(etcc_pkg::OPD_A2, etcc_pkg::OPD_C2, etcc_pkg::DST_AB,
                            etcc_pkg::ACC_HOLD, etcc_pkg::SH_0);
            5'd10: uc = mul(etcc_pkg::OPD_B2, etcc_pkg::OPD_C2, etcc_pkg::DST_AC,
                            etcc_pkg::ACC_HOLD, etcc_pkg::SH_0);
            // dy^2 * a^2 c^2
            5'd11: uc = mul(etcc_pkg::OPD_DY2_LO, etcc_pkg::OPD_AC_LO, etcc_pkg::DST_BC,
                            etcc_pkg::ACC_HOLD, etcc_pkg::SH_0);
            5'd12: uc = mul(etcc_pkg::OPD_DY2_LO, etcc_pkg::OPD_AC_HI, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_ADD, etcc_pkg::SH_0);
            5'd13: uc = mul(etcc_pkg::OPD_DY2_HI, etcc_pkg::OPD_AC_LO, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_ADD, etcc_pkg::SH_32);
            5'd14: uc = mul(etcc_pkg::OPD_DY2_HI, etcc_pkg::OPD_AC_HI, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_ADD, etcc_pkg::SH_32);
            // dx^2 * b^2 c^2
            5'd15: uc = mul(etcc_pkg::OPD_DX2_LO, etcc_pkg::OPD_BC_LO, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_ADD, etcc_pkg::SH_64);
            5'd16: uc = mul(etcc_pkg::OPD_DX2_LO, etcc_pkg::OPD_BC_HI, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_ADD, etcc_pkg::SH_0);
            5'd17: uc = mul(etcc_pkg::OPD_DX2_HI, etcc_pkg::OPD_BC_LO, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_ADD, etcc_pkg::SH_32);
            5'd18: uc = mul(etcc_pkg::OPD_DX2_HI, etcc_pkg::OPD_BC_HI, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_ADD, etcc_pkg::SH_32);
            // dz^2 * a^2 b^2
            5'd19: uc = mul(etcc_pkg::OPD_DZ2_LO, etcc_pkg::OPD_AB_LO, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_ADD, etcc_pkg::SH_64);
            5'd20: uc = mul(etcc_pkg::OPD_DZ2_LO, etcc_pkg::OPD_AB_HI, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_ADD, etcc_pkg::SH_0);
            5'd21: uc = mul(etcc_pkg::OPD_DZ2_HI, etcc_pkg::OPD_AB_LO, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_ADD, etcc_pkg::SH_32);
            5'd22: uc = mul(etcc_pkg::OPD_DZ2_HI, etcc_pkg::OPD_AB_HI, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_ADD, etcc_pkg::SH_32);
            // subtract a^2 b^2 c^2
            5'd23: uc = mul(etcc_pkg::OPD_AB_LO, etcc_pkg::OPD_C2, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_ADD, etcc_pkg::SH_64);
            5'd24: uc = mul(etcc_pkg::OPD_AB_HI, etcc_pkg::OPD_C2, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_SUB, etcc_pkg::SH_0);
            5'd25: uc = mul(etcc_pkg::OPD_ZERO, etcc_pkg::OPD_ZERO, etcc_pkg::DST_NONE,
                            etcc_pkg::ACC_SUB, etcc_pkg::SH_32);
            5'd26: uc = uw(etcc_pkg::SEQ_CHECK, PC_TEST, 1'b0, 1'b0, etcc_pkg::OPD_ZERO,
                           etcc_pkg::OPD_ZERO, etcc_pkg::DST_NONE, etcc_pkg::ACC_HOLD,
                           etcc_pkg::SH_0);
            5'd27: uc = uw(etcc_pkg::SEQ_EMIT_HIT, PC_WAIT, 1'b0, 1'b0, etcc_pkg::OPD_ZERO,
                           etcc_pkg::OPD_ZERO, etcc_pkg::DST_NONE, etcc_pkg::ACC_HOLD,
                           etcc_pkg::SH_0);
            5'd28: uc = uw(etcc_pkg::SEQ_EMIT_SAFE, PC_WAIT, 1'b0, 1'b0, etcc_pkg::OPD_ZERO,
                           etcc_pkg::OPD_ZERO, etcc_pkg::DST_NONE, etcc_pkg::ACC_HOLD,
                           etcc_pkg::SH_0);
            default: uc = uw(etcc_pkg::SEQ_JUMP, PC_WAIT, 1'b0, 1'b0, etcc_pkg::OPD_ZERO,
                             etcc_pkg::OPD_ZERO, etcc_pkg::DST_NONE, etcc_pkg::ACC_HOLD,
                             etcc_pkg::SH_0);
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/etcc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etcc_datapath: threat table, operand registers, shared multiplier
// One 32x32 multiplier feeds a product register; the product goes either
// to a named scratch register or into a signed accumulator at a limb shift.
// ----------------------------------------------------------------------------
module etcc_datapath #(
    parameter  int MAX_THREATS = etcc_pkg::MAX_THREATS_DEF,
    localparam int IDX_W       = (MAX_THREATS > 1) ? $clog2(MAX_THREATS) : 1
) (
    input  wire logic               aclk,
    input  wire etcc_pkg::in_word_t s_data,
    input  wire etcc_pkg::dp_ctrl_t ctrl,
    input  wire logic [IDX_W-1:0]   wr_addr,
    input  wire logic [IDX_W-1:0]   rd_addr,
    output etcc_pkg::dp_stat_t      stat
);

    localparam int OW = etcc_pkg::OPND_W;
    localparam int PW = etcc_pkg::PROD_W;
    localparam int AW = etcc_pkg::ACC_W;
    localparam int DW = etcc_pkg::DIFF_W;
    localparam int SW = etcc_pkg::SQ_W;
    localparam int CW = etcc_pkg::COORD_W;

    etcc_pkg::threat_ent_t mem [MAX_THREATS];
    etcc_pkg::threat_ent_t ent_reg;
    etcc_pkg::threat_ent_t wr_ent;

    logic signed [CW-1:0] px_reg, py_reg, pz_reg;
    logic [DW-1:0]        dx_reg, dy_reg, dz_reg;
    logic [OW-1:0]        a2_reg, b2_reg, c2_reg;
    logic [PW-1:0]        ab_reg, ac_reg, bc_reg;
    logic [SW-1:0]        dx2_reg, dy2_reg, dz2_reg;
    logic [PW-1:0]        prod_reg;
    logic [AW-1:0]        acc_reg;
    logic [AW-1:0]        addend;
    logic [OW-1:0]        opa, opb;

    function automatic logic [DW-1:0] abs_diff(
        input logic signed [CW-1:0] p,
        input logic signed [CW-1:0] c
    );
        logic signed [CW:0] d;
        logic signed [CW:0] m;
        d = (CW+1)'(p) - (CW+1)'(c);
        m = (d < 0) ? -d : d;
        return m[DW-1:0];
    endfunction

    function automatic logic [OW-1:0] pick(input etcc_pkg::opnd_t s);
        logic [OW-1:0] v;
        unique case (s)
            etcc_pkg::OPD_ZERO:   v = '0;
            etcc_pkg::OPD_A:      v = OW'(ent_reg.a);
            etcc_pkg::OPD_B:      v = OW'(ent_reg.b);
            etcc_pkg::OPD_C:      v = OW'(ent_reg.c);
            etcc_pkg::OPD_DX:     v = OW'(dx_reg);
            etcc_pkg::OPD_DY:     v = OW'(dy_reg);
            etcc_pkg::OPD_DZ:     v = OW'(dz_reg);
            etcc_pkg::OPD_A2:     v = a2_reg;
            etcc_pkg::OPD_B2:     v = b2_reg;
            etcc_pkg::OPD_C2:     v = c2_reg;
            etcc_pkg::OPD_AB_LO:  v = ab_reg[OW-1:0];
            etcc_pkg::OPD_AB_HI:  v = ab_reg[PW-1:OW];
            etcc_pkg::OPD_AC_LO:  v = ac_reg[OW-1:0];
            etcc_pkg::OPD_AC_HI:  v = ac_reg[PW-1:OW];
            etcc_pkg::OPD_BC_LO:  v = bc_reg[OW-1:0];
            etcc_pkg::OPD_BC_HI:  v = bc_reg[PW-1:OW];
            etcc_pkg::OPD_DX2_LO: v = dx2_reg[OW-1:0];
            etcc_pkg::OPD_DX2_HI: v = OW'(dx2_reg[SW-1:OW]);
            etcc_pkg::OPD_DY2_LO: v = dy2_reg[OW-1:0];
            etcc_pkg::OPD_DY2_HI: v = OW'(dy2_reg[SW-1:OW]);
            etcc_pkg::OPD_DZ2_LO: v = dz2_reg[OW-1:0];
            etcc_pkg::OPD_DZ2_HI: v = OW'(dz2_reg[SW-1:OW]);
            default:              v = '0;
        endcase
        return v;
    endfunction

    // Pack a load word into a table entry
    always_comb begin
        wr_ent.cx = s_data.pos_x;
        wr_ent.cy = s_data.pos_y;
        wr_ent.cz = s_data.pos_z;
        wr_ent.a  = s_data.semi_a;
        wr_ent.b  = s_data.semi_b;
        wr_ent.c  = s_data.semi_c;
    end

    // Threat table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ctrl.mem_we) begin
            mem[wr_addr] <= wr_ent;
        end
        if (ctrl.rd_en) begin
            ent_reg <= mem[rd_addr];
        end
    end

    // Hold the query point; form distances to the fetched center
    always_ff @(posedge aclk) begin
        if (ctrl.pt_ld) begin
            px_reg <= s_data.pos_x;
            py_reg <= s_data.pos_y;
            pz_reg <= s_data.pos_z;
        end
        if (ctrl.ld_diff) begin
            dx_reg <= abs_diff(px_reg, ent_reg.cx);
            dy_reg <= abs_diff(py_reg, ent_reg.cy);
            dz_reg <= abs_diff(pz_reg, ent_reg.cz);
        end
    end

    // Shared multiplier
    always_comb begin
        opa = pick(ctrl.opa);
        opb = pick(ctrl.opb);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= opa * opb;
    end

    // Store the previous product into a scratch register
    always_ff @(posedge aclk) begin
        unique case (ctrl.dst)
            etcc_pkg::DST_NONE: ;
            etcc_pkg::DST_A2:   a2_reg  <= prod_reg[OW-1:0];
            etcc_pkg::DST_B2:   b2_reg  <= prod_reg[OW-1:0];
            etcc_pkg::DST_C2:   c2_reg  <= prod_reg[OW-1:0];
            etcc_pkg::DST_AB:   ab_reg  <= prod_reg;
            etcc_pkg::DST_AC:   ac_reg  <= prod_reg;
            etcc_pkg::DST_BC:   bc_reg  <= prod_reg;
            etcc_pkg::DST_DX2:  dx2_reg <= prod_reg[SW-1:0];
            etcc_pkg::DST_DY2:  dy2_reg <= prod_reg[SW-1:0];
            etcc_pkg::DST_DZ2:  dz2_reg <= prod_reg[SW-1:0];
            default: ;
        endcase
    end

    // Align the product to its limb position
    always_comb begin
        unique case (ctrl.shift)
            etcc_pkg::SH_0:  addend = AW'(prod_reg);
            etcc_pkg::SH_32: addend = AW'({prod_reg, {OW{1'b0}}});
            etcc_pkg::SH_64: addend = AW'({prod_reg, {(2*OW){1'b0}}});
            default:         addend = '0;
        endcase
    end

    // Accumulate lhs - rhs
    always_ff @(posedge aclk) begin
        unique case (ctrl.acc)
            etcc_pkg::ACC_HOLD: ;
            etcc_pkg::ACC_CLR:  acc_reg <= '0;
            etcc_pkg::ACC_ADD:  acc_reg <= acc_reg + addend;
            etcc_pkg::ACC_SUB:  acc_reg <= acc_reg - addend;
            default: ;
        endcase
    end

    // Negative difference means strictly inside
    assign stat.acc_neg = acc_reg[AW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/etcc_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etcc_seq: step counter, entry counter and result register
// Runs the microprogram, takes input words at the wait step, and posts
// results into an output register that the consumer drains.
// ----------------------------------------------------------------------------
module etcc_seq #(
    parameter  int MAX_THREATS = etcc_pkg::MAX_THREATS_DEF,
    localparam int IDX_W       = (MAX_THREATS > 1) ? $clog2(MAX_THREATS) : 1,
    localparam int CNT_W       = $clog2(MAX_THREATS + 1)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [etcc_pkg::COUNT_W-1:0]    cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_op,
    input  wire logic [etcc_pkg::SLOT_W-1:0]     s_slot,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output etcc_pkg::out_word_t                  m_data,
    input  wire etcc_pkg::ctrl_word_t            uc,
    output logic [etcc_pkg::PC_W-1:0]            pc,
    input  wire etcc_pkg::dp_stat_t              stat,
    output etcc_pkg::dp_ctrl_t                   ctrl,
    output logic [IDX_W-1:0]                     wr_addr,
    output logic [IDX_W-1:0]                     rd_addr
);

    logic [etcc_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]             n_reg, n_next;
    logic [etcc_pkg::COUNT_W-1:0] count_reg;
    logic                         m_valid_reg, m_valid_next;
    etcc_pkg::out_word_t          m_data_reg, m_data_next;
    logic                         accept;
    logic                         is_query;
    logic                         slot_ok;
    logic                         out_free;

    assign s_ready  = (uc.seq == etcc_pkg::SEQ_WAIT);
    assign accept   = s_valid && s_ready;
    assign is_query = (s_op == etcc_pkg::OP_QUERY);
    assign slot_ok  = (32'(s_slot) < 32'(MAX_THREATS));
    assign out_free = !m_valid_reg || m_ready;

    // Drive the datapath from the current control word
    always_comb begin
        ctrl.mem_we  = accept && !is_query && slot_ok;
        ctrl.pt_ld   = accept && is_query;
        ctrl.rd_en   = uc.rd_en;
        ctrl.ld_diff = uc.ld_diff;
        ctrl.opa     = uc.opa;
        ctrl.opb     = uc.opb;
        ctrl.dst     = uc.dst;
        ctrl.acc     = uc.acc;
        ctrl.shift   = uc.shift;
        wr_addr      = IDX_W'(s_slot);
        rd_addr      = idx_reg[IDX_W-1:0];
    end

    // Clamp the entry count at query start
    always_comb begin
        if (32'(count_reg) > 32'(MAX_THREATS)) begin
            n_next = CNT_W'(MAX_THREATS);
        end else begin
            n_next = CNT_W'(count_reg);
        end
    end

    // Step and entry sequencing, result posting
    always_comb begin
        pc_next      = pc_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (uc.seq)
            etcc_pkg::SEQ_WAIT: begin
                if (accept && is_query) begin
                    pc_next  = etcc_pkg::PC_W'(pc_reg + 1'b1);
                    idx_next = '0;
                end
            end
            etcc_pkg::SEQ_NEXT: begin
                pc_next = etcc_pkg::PC_W'(pc_reg + 1'b1);
            end
            etcc_pkg::SEQ_JUMP: begin
                pc_next = uc.target;
            end
            etcc_pkg::SEQ_TEST: begin
                if (idx_reg >= n_reg) begin
                    pc_next = uc.target;
                end else begin
                    pc_next = etcc_pkg::PC_W'(pc_reg + 1'b1);
                end
            end
            etcc_pkg::SEQ_CHECK: begin
                if (stat.acc_neg) begin
                    pc_next = etcc_pkg::PC_W'(pc_reg + 1'b1);
                end else begin
                    pc_next  = uc.target;
                    idx_next = CNT_W'(idx_reg + 1'b1);
                end
            end
            etcc_pkg::SEQ_EMIT_HIT: begin
                if (out_free) begin
                    pc_next               = uc.target;
                    m_valid_next          = 1'b1;
                    m_data_next.safe      = 1'b0;
                    m_data_next.hit_index = etcc_pkg::HIT_W'(idx_reg);
                end
            end
            etcc_pkg::SEQ_EMIT_SAFE: begin
                if (out_free) begin
                    pc_next               = uc.target;
                    m_valid_next          = 1'b1;
                    m_data_next.safe      = 1'b1;
                    m_data_next.hit_index = '0;
                end
            end
            default: begin
                pc_next = uc.target;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= '0;
            idx_reg     <= '0;
            n_reg       <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (accept && is_query) begin
                n_reg <= n_next;
            end
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign pc      = pc_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ellipsoid_threat_clearance_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ellipsoid_threat_clearance_check: point test against ellipsoid threat zones
// Keeps a table of axis-aligned ellipsoids and tests query points against
// the first min(threat_count, MAX_THREATS) entries, exactly, with no division.
//
//   channel  dir  handshake          word
//   s_       in   s_valid/s_ready    in_word_t  (load entry or query point)
//   m_       out  m_valid/m_ready    out_word_t (safe, hit_index)
//   cfg_     in   cfg_we             threat_count, no wait
//
// A load word is written at accept and posts nothing. Each entry walked runs
// a fetch, distance, 23 products on the one shared 32x32 multiplier and a
// decision. A safe result is posted once all n entries are checked with no
// hit; a hit is posted at the first entry walked that holds the point, with
// its index. The input reopens the cycle after posting.
// Reset is synchronous; the table needs no clearing pass.
// A waiting result does not block input words; a new result waits for the
// output register to drain.
// ----------------------------------------------------------------------------
module ellipsoid_threat_clearance_check #(
    parameter int MAX_THREATS = etcc_pkg::MAX_THREATS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [etcc_pkg::COUNT_W-1:0] cfg_wdata,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire etcc_pkg::in_word_t           s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output etcc_pkg::out_word_t               m_data
);

    localparam int IDX_W = (MAX_THREATS > 1) ? $clog2(MAX_THREATS) : 1;

    etcc_pkg::ctrl_word_t      uc;
    etcc_pkg::dp_ctrl_t        ctrl;
    etcc_pkg::dp_stat_t        stat;
    logic [etcc_pkg::PC_W-1:0] pc;
    logic [IDX_W-1:0]          wr_addr;
    logic [IDX_W-1:0]          rd_addr;

    etcc_ucode_rom u_rom (
        .pc (pc),
        .uc (uc)
    );

    etcc_seq #(
        .MAX_THREATS (MAX_THREATS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_data.op),
        .s_slot    (s_data.slot),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .uc        (uc),
        .pc        (pc),
        .stat      (stat),
        .ctrl      (ctrl),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr)
    );

    etcc_datapath #(
        .MAX_THREATS (MAX_THREATS)
    ) u_dp (
        .aclk    (aclk),
        .s_data  (s_data),
        .ctrl    (ctrl),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .stat    (stat)
    );

`ifndef SYNTHESIS
    // A query word closes the input until its result is posted
    a_query_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.op == etcc_pkg::OP_QUERY) |=> !s_ready)
        else $error("input still open after a query word");

    // A load word leaves the block ready for the next word
    a_load_stays_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.op == etcc_pkg::OP_LOAD) |=> s_ready)
        else $error("input closed after a load word");

    // A safe result carries index zero
    a_safe_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.safe) |-> (m_data.hit_index == '0))
        else $error("safe result with nonzero hit index");

    // A result only appears while the sequencer is busy with a query
    a_result_from_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result posted while waiting for input");
`endif

endmodule
`default_nettype wire

// ===== test/clearance_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clearance_checker: verdict checker for the ellipsoid clearance block
// Watches the register port and both word channels. Keeps its own copy of
// the threat table and of threat_count, works out the verdict of every
// accepted query and compares it, field by field, with the words leaving
// the block in order.
// ----------------------------------------------------------------------------
module clearance_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [etcc_pkg::COUNT_W-1:0] cfg_wdata,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  etcc_pkg::in_word_t           s_data,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  etcc_pkg::out_word_t          m_data,
    output int                           fail_count,
    output int                           verdicts_owed,
    output int                           loads_seen,
    output int                           queries_seen,
    output int                           hits_seen
);

    localparam int TABLE_DEPTH   = etcc_pkg::MAX_THREATS_DEF;
    localparam int VERDICT_DEPTH = 64;

    etcc_pkg::threat_ent_t        zone_table [TABLE_DEPTH];
    logic [etcc_pkg::COUNT_W-1:0] zone_count;
    etcc_pkg::out_word_t          pending_verdicts [VERDICT_DEPTH];
    int                           vq_head = 0;
    int                           vq_tail = 0;
    int                           err_n   = 0;
    int                           n_loads = 0;
    int                           n_query = 0;
    int                           n_hits  = 0;

    // Distance of a point from a center along one axis, always below 2^20
    function automatic logic [19:0] axis_gap(input logic signed [19:0] p,
                                             input logic signed [19:0] c);
        int d;
        d = int'(p) - int'(c);
        if (d < 0) begin
            d = -d;
        end
        return d[19:0];
    endfunction

    // Strict inside test, cross-multiplied so no division is needed
    function automatic logic point_in_zone(input etcc_pkg::threat_ent_t zn,
                                           input logic signed [19:0] px,
                                           input logic signed [19:0] py,
                                           input logic signed [19:0] pz);
        logic [127:0] gx, gy, gz, a2, b2, c2, lhs, rhs;
        gx  = axis_gap(px, zn.cx);
        gy  = axis_gap(py, zn.cy);
        gz  = axis_gap(pz, zn.cz);
        a2  = zn.a;
        b2  = zn.b;
        c2  = zn.c;
        a2  = a2 * a2;
        b2  = b2 * b2;
        c2  = c2 * c2;
        lhs = gx * gx * b2 * c2 + gy * gy * a2 * c2 + gz * gz * a2 * b2;
        rhs = a2 * b2 * c2;
        return lhs < rhs;
    endfunction

    // Walk the active entries and report the lowest one holding the point
    function automatic etcc_pkg::out_word_t predict_clearance(
        input logic signed [19:0] px,
        input logic signed [19:0] py,
        input logic signed [19:0] pz
    );
        etcc_pkg::out_word_t v;
        int                  lim;
        v.safe      = 1'b1;
        v.hit_index = '0;
        lim = (zone_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(zone_count);
        for (int i = 0; i < lim; i++) begin
            if (point_in_zone(zone_table[i], px, py, pz)) begin
                v.safe      = 1'b0;
                v.hit_index = 5'(i);
                break;
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] clearance mismatch: %s: got %0d, expected %0d",
                 $time, what, got, want);
        err_n++;
    endtask

    always @(posedge aclk) begin : watch
        etcc_pkg::out_word_t   want;
        etcc_pkg::threat_ent_t ent;
        if (!aresetn) begin
            zone_count = '0;
            vq_head    = 0;
            vq_tail    = 0;
        end else begin
            if (cfg_we) begin
                zone_count = cfg_wdata;
            end
            // compare the leaving word first: it answers an older query
            if (m_valid && m_ready) begin
                if (vq_tail == vq_head) begin
                    report_mismatch("result word with no query owed, safe",
                                    int'(m_data.safe), -1);
                end else begin
                    want = pending_verdicts[vq_head % VERDICT_DEPTH];
                    vq_head++;
                    if (m_data.safe !== want.safe) begin
                        report_mismatch("safe", int'(m_data.safe), int'(want.safe));
                    end
                    if (m_data.hit_index !== want.hit_index) begin
                        report_mismatch("hit_index", int'(m_data.hit_index),
                                        int'(want.hit_index));
                    end
                    if (!want.safe) begin
                        n_hits++;
                    end
                end
            end
            // take the incoming word: a load updates the table, a query owes a verdict
            if (s_valid && s_ready) begin
                if (s_data.op == etcc_pkg::OP_LOAD) begin
                    ent.cx = s_data.pos_x;
                    ent.cy = s_data.pos_y;
                    ent.cz = s_data.pos_z;
                    ent.a  = s_data.semi_a;
                    ent.b  = s_data.semi_b;
                    ent.c  = s_data.semi_c;
                    zone_table[s_data.slot] = ent;
                    n_loads++;
                end else begin
                    if (vq_tail - vq_head >= VERDICT_DEPTH) begin
                        report_mismatch("verdicts owed beyond checker depth",
                                        vq_tail - vq_head, VERDICT_DEPTH - 1);
                    end
                    pending_verdicts[vq_tail % VERDICT_DEPTH] =
                        predict_clearance(s_data.pos_x, s_data.pos_y, s_data.pos_z);
                    vq_tail++;
                    n_query++;
                end
            end
        end
        fail_count    <= err_n;
        verdicts_owed <= vq_tail - vq_head;
        loads_seen    <= n_loads;
        queries_seen  <= n_query;
        hits_seen     <= n_hits;
    end

endmodule

// ===== test/ellipsoid_threat_clearance_check_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipsoid_threat_clearance_check_tb: stimulus and verdict for the block
// Loads threat zones and sends query points through random gaps and
// stalls, steps threat_count through its range between phases, and leaves
// all checking to the clearance checker beside the block.
// ----------------------------------------------------------------------------
module ellipsoid_threat_clearance_check_tb;

    localparam int TABLE_DEPTH    = etcc_pkg::MAX_THREATS_DEF;
    localparam int GAP_MAX        = 18;
    localparam int SETTLE_CYCLES  = 900;
    localparam int HOLDOFF_CYCLES = 2000;
    localparam int STALL_LIMIT    = 20000;
    localparam int PHASE_WORDS    = 90;
    localparam int N_PHASES       = 10;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_we;
    logic [etcc_pkg::COUNT_W-1:0] cfg_wdata;
    logic                         s_valid;
    logic                         s_ready;
    etcc_pkg::in_word_t           s_data;
    logic                         m_valid;
    logic                         m_ready;
    etcc_pkg::out_word_t          m_data;

    int fail_count;
    int verdicts_owed;
    int loads_seen;
    int queries_seen;
    int hits_seen;

    etcc_pkg::in_word_t           zone_shadow [TABLE_DEPTH];
    logic                         zone_loaded [TABLE_DEPTH];
    logic [etcc_pkg::COUNT_W-1:0] zone_count_now = '0;
    int                           settings_used  = 0;
    int                           idle_cycles    = 0;
    logic                         holdoff_req    = 1'b0;
    bit                           s_burst        = 1'b0;
    bit                           m_burst        = 1'b0;

    ellipsoid_threat_clearance_check uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    clearance_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .verdicts_owed (verdicts_owed),
        .loads_seen    (loads_seen),
        .queries_seen  (queries_seen),
        .hits_seen     (hits_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort when no word moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("** ellipsoid_threat_clearance_check: FAILED **");
            $finish;
        end
    end

    // Result sink: random stalls, bursts with none, one long hold-off on request
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        forever begin
            if (holdoff_req) begin
                m_ready     <= 1'b0;
                holdoff_req <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
            end else begin
                if ($urandom_range(24, 0) == 0) begin
                    m_burst = !m_burst;
                end
                stall = m_burst ? 0 : $urandom_range(GAP_MAX, 0);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic logic [15:0] pick_axis();
        int r;
        r = $urandom_range(99, 0);
        if (r < 3) begin
            return '0;
        end
        if (r < 15) begin
            return 16'($urandom());
        end
        return 16'($urandom_range(4000, 1));
    endfunction

    function automatic logic [19:0] pick_coord();
        if ($urandom_range(4, 0) == 0) begin
            return 20'($urandom());
        end
        return 20'(int'($urandom_range(16383, 0)) - 8192);
    endfunction

    // Query word with the fields a query ignores filled at random
    function automatic etcc_pkg::in_word_t make_point(input int x, input int y, input int z);
        etcc_pkg::in_word_t w;
        w.op     = etcc_pkg::OP_QUERY;
        w.slot   = 5'($urandom());
        w.pos_x  = 20'(x);
        w.pos_y  = 20'(y);
        w.pos_z  = 20'(z);
        w.semi_a = 16'($urandom());
        w.semi_b = 16'($urandom());
        w.semi_c = 16'($urandom());
        return w;
    endfunction

    function automatic etcc_pkg::in_word_t make_zone(input int slot, input int x, input int y,
                                                     input int z, input int a, input int b,
                                                     input int c);
        etcc_pkg::in_word_t w;
        w.op     = etcc_pkg::OP_LOAD;
        w.slot   = 5'(slot);
        w.pos_x  = 20'(x);
        w.pos_y  = 20'(y);
        w.pos_z  = 20'(z);
        w.semi_a = 16'(a);
        w.semi_b = 16'(b);
        w.semi_c = 16'(c);
        return w;
    endfunction

    function automatic etcc_pkg::in_word_t random_zone(input int slot);
        return make_zone(slot, int'($signed(pick_coord())), int'($signed(pick_coord())),
                         int'($signed(pick_coord())), pick_axis(), pick_axis(), pick_axis());
    endfunction

    // Mostly aim at an active zone (inside, near or on its surface), else anywhere
    function automatic etcc_pkg::in_word_t random_query();
        etcc_pkg::in_word_t e;
        int n, k, cx, cy, cz, sa, sb, sc, ax, sgn;
        n = (zone_count_now > TABLE_DEPTH) ? TABLE_DEPTH : int'(zone_count_now);
        if (n == 0 || $urandom_range(99, 0) >= 75) begin
            return make_point(int'($signed(pick_coord())), int'($signed(pick_coord())),
                              int'($signed(pick_coord())));
        end
        k  = $urandom_range(n - 1, 0);
        e  = zone_shadow[k];
        cx = int'(e.pos_x);
        cy = int'(e.pos_y);
        cz = int'(e.pos_z);
        sa = int'(e.semi_a);
        sb = int'(e.semi_b);
        sc = int'(e.semi_c);
        if ($urandom_range(99, 0) < 15) begin
            ax  = $urandom_range(2, 0);
            sgn = $urandom_range(1, 0) ? 1 : -1;
            return make_point(cx + ((ax == 0) ? sgn * sa : 0),
                              cy + ((ax == 1) ? sgn * sb : 0),
                              cz + ((ax == 2) ? sgn * sc : 0));
        end
        if ($urandom_range(1, 0) == 0) begin
            sa = sa + sa / 4;
            sb = sb + sb / 4;
            sc = sc + sc / 4;
        end
        return make_point(cx + int'($urandom_range(2 * sa, 0)) - sa,
                          cy + int'($urandom_range(2 * sb, 0)) - sb,
                          cz + int'($urandom_range(2 * sc, 0)) - sc);
    endfunction

    // Offer one word after a random gap, hold it until accepted
    task automatic offer_word(input etcc_pkg::in_word_t w);
        int gap;
        if ($urandom_range(29, 0) == 0) begin
            s_burst = !s_burst;
        end
        gap = s_burst ? 0 : $urandom_range(GAP_MAX, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        if (w.op == etcc_pkg::OP_LOAD) begin
            zone_shadow[w.slot] = w;
            zone_loaded[w.slot] = 1'b1;
        end
    endtask

    // Stop offering until every owed verdict has left the block
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (verdicts_owed != 0);
    endtask

    task automatic set_zone_count(input int v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 6'(v);
        @(posedge aclk);
        cfg_we         <= 1'b0;
        zone_count_now  = 6'(v);
        settings_used++;
    endtask

    initial begin : stimulus
        int phase_counts [N_PHASES];
        phase_counts = '{32, 1, 63, 17, 0, 33, 9, 32, 2, 24};
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            zone_loaded[i] = 1'b0;
        end
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // count of zero after reset: every point is clear
        offer_word(make_point(-524288, 524287, -524288));

        // hand-placed zones: small, table-corner maximal, zero axis, overlapping
        offer_word(make_zone(0, 0, 0, 0, 16, 32, 48));
        offer_word(make_zone(1, -524288, 524287, -524288, 65535, 65535, 65535));
        offer_word(make_zone(2, 100, 100, 100, 0, 50, 50));
        offer_word(make_zone(3, 0, 4, 0, 65535, 1, 1));
        set_zone_count(4);
        offer_word(make_point(0, 0, 0));
        offer_word(make_point(16, 0, 0));
        offer_word(make_point(15, 0, 0));
        offer_word(make_point(0, 0, -47));
        offer_word(make_point(0, 4, 0));
        offer_word(make_point(1000, 4, 0));
        offer_word(make_point(-524288, 524287, -524288));
        offer_word(make_point(-458753, 524287, -524288));
        offer_word(make_point(524287, -524288, 524287));
        offer_word(make_point(100, 100, 100));

        // fill the rest of the table before any count reaches it
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!zone_loaded[i]) begin
                offer_word(random_zone(i));
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            set_zone_count(phase_counts[p]);
            for (int j = 0; j < PHASE_WORDS; j++) begin
                if (p == 2 && j == 10) begin
                    holdoff_req <= 1'b1;
                end
                if (p == 4 && j == 45) begin
                    drain_results();
                end
                if ($urandom_range(99, 0) < 35) begin
                    offer_word(random_zone($urandom_range(TABLE_DEPTH - 1, 0)));
                end else begin
                    offer_word(random_query());
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("run covered %0d zone loads and %0d point queries (%0d inside a zone)",
                 loads_seen, queries_seen, hits_seen);
        $display("threat_count took %0d settings from 0 to 63; one long result hold-off",
                 settings_used);
        if (fail_count == 0 && verdicts_owed == 0) begin
            $display("** ellipsoid_threat_clearance_check: PASSED **");
        end else begin
            $display("** ellipsoid_threat_clearance_check: FAILED **");
        end
        $finish;
    end

endmodule
